// ===== design/som_pkg.sv =====
`timescale 1ns / 1ps
package som_pkg;

    localparam int UNIT_W   = 8;
    localparam int ATTR_W   = 16;
    localparam int ATTR_MAX = 3;
    localparam int WORD_W   = ATTR_W * ATTR_MAX;
    localparam int DEPTH    = 256;
    localparam int SCALE_W  = 24;
    localparam int LR_W     = 16;
    localparam int DIST_W   = 34;
    localparam int COORD_W  = 4;
    localparam int CMD_W    = 2;
    localparam int MUL_W    = 25;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int EXP_N    = 256;

    localparam int MAP_DIMS_DEF  = 2;
    localparam int MAP_WIDTH_DEF = 16;
    localparam int ATTRS_DEF     = 3;

    localparam logic [LR_W-1:0] LR_RESET = 16'd7864;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRAIN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [63:0] EXP_STEP = 64'd4034748382;

    typedef logic [EXP_N-1:0][15:0] t_exp_tab;
    typedef logic [WORD_W-1:0] t_word;

    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    tab;
        logic [63:0] r;
        logic [63:0] e;
        r = 64'd1 << 32;
        for (int i = 0; i < EXP_N; i++) begin
            e = (r + 64'd32768) >> 16;
            tab[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
            r = (r * EXP_STEP + 64'h8000_0000) >> 32;
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

// ===== design/som_wmem.sv =====
`timescale 1ns / 1ps
module som_wmem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [som_pkg::UNIT_W-1:0]  i_waddr,
    input  som_pkg::t_word              i_wdata,
    input  logic [som_pkg::UNIT_W-1:0]  i_raddr,
    output som_pkg::t_word              o_rdata
);
    import som_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/som_mul.sv =====
`timescale 1ns / 1ps
module som_mul (
    input  logic                               i_clk,
    input  logic signed [som_pkg::MUL_W-1:0]   i_a,
    input  logic signed [som_pkg::MUL_W-1:0]   i_b,
    output logic signed [som_pkg::PROD_W-1:0]  o_prod
);
    import som_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

// ===== design/self_organizing_map_engine.sv =====
// Load: written at the accept edge; the engine stays ready.
// Query: searches every unit, one squared difference per cycle through the
//   shared multiplier.
// Train: a query, then a pass over every unit: three steps for the gain,
//   then one per attribute, then the write.
// Reset: sequencer idle, output empty, learning_rate 7864; weights undefined until loaded.
`timescale 1ns / 1ps
module self_organizing_map_engine #(
    parameter int MAP_DIMS  = som_pkg::MAP_DIMS_DEF,
    parameter int MAP_WIDTH = som_pkg::MAP_WIDTH_DEF,
    parameter int ATTRS     = som_pkg::ATTRS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [som_pkg::CMD_W-1:0]           i_cmd,
    input  logic [som_pkg::UNIT_W-1:0]          i_unit_index,
    input  logic signed [som_pkg::ATTR_W-1:0]   i_attr_a,
    input  logic signed [som_pkg::ATTR_W-1:0]   i_attr_b,
    input  logic signed [som_pkg::ATTR_W-1:0]   i_attr_c,
    input  logic [som_pkg::SCALE_W-1:0]         i_neighborhood_scale,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [som_pkg::UNIT_W-1:0]          o_bmu_index,
    output logic [som_pkg::COORD_W-1:0]         o_coord_x,
    output logic [som_pkg::COORD_W-1:0]         o_coord_y,
    output logic [som_pkg::DIST_W-1:0]          o_best_distance,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [som_pkg::LR_W-1:0]            i_cfg_data
);
    import som_pkg::*;

    localparam int UNIT_COUNT = (MAP_DIMS == 1) ? MAP_WIDTH : MAP_WIDTH * MAP_WIDTH;
    localparam int STEP_W     = 3;
    localparam int STEP_FEED  = 3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SRCH = 4'b0010,
        S_UPD  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [UNIT_W-1:0]        r_unit, n_unit;
    logic [STEP_W-1:0]        r_step;
    logic [COORD_W-1:0]       r_x, r_y;
    logic [CMD_W-1:0]         r_cmd;
    logic [SCALE_W-1:0]       r_scale;
    logic [LR_W-1:0]          r_lr;
    logic signed [ATTR_W-1:0] r_samp [ATTR_MAX];
    logic [DIST_W-1:0]        r_acc, r_best;
    logic [UNIT_W-1:0]        r_bi;
    logic [COORD_W-1:0]       r_bx, r_by;
    logic [15:0]              r_gain;
    t_word                    r_neww;
    logic                     r_ovalid;
    logic [UNIT_W-1:0]        r_obi;
    logic [COORD_W-1:0]       r_obx, r_oby;
    logic [DIST_W-1:0]        r_odist;

    t_word                    rdata, wdata, upd_word;
    logic                     mem_we;
    logic [UNIT_W-1:0]        waddr;
    logic signed [ATTR_W:0]   diff [ATTR_MAX];
    logic signed [ATTR_W-1:0] w_attr [ATTR_MAX];
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [1:0]               k_s, k_f, k_r;
    logic [DIST_W-1:0]        dist_sum;
    logic signed [4:0]        dx, dy;
    logic [8:0]               ld2;
    logic [16:0]              exp_e;
    logic [32:0]              gain_sum;
    logic signed [PROD_W-1:0] rnd;
    logic [ATTR_W-1:0]        new_w;
    logic                     in_acc, srch_end, upd_end, last_unit, x_last, out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign srch_end    = (r_state == S_SRCH) && (r_step == STEP_W'(ATTRS));
    assign upd_end     = (r_state == S_UPD) && (r_step == STEP_W'(ATTRS + STEP_FEED));
    assign last_unit   = (r_unit == UNIT_W'(UNIT_COUNT - 1));
    assign x_last      = (r_x == COORD_W'(MAP_WIDTH - 1));
    assign out_free    = !r_ovalid || i_out_ready;

    always_comb begin
        for (int k = 0; k < ATTR_MAX; k++) begin
            w_attr[k] = rdata[k*ATTR_W +: ATTR_W];
            diff[k]   = (ATTR_W+1)'(r_samp[k]) - (ATTR_W+1)'(w_attr[k]);
        end
    end

    always_comb begin
        k_s = (r_step < STEP_W'(ATTRS)) ? r_step[1:0] : 2'd0;
        k_f = 2'd0;
        k_r = 2'd0;
        if (r_step >= STEP_W'(STEP_FEED) && r_step < STEP_W'(STEP_FEED + ATTRS)) begin
            k_f = 2'(r_step - STEP_W'(STEP_FEED));
        end
        if (r_step > STEP_W'(STEP_FEED) && r_step <= STEP_W'(STEP_FEED + ATTRS)) begin
            k_r = 2'(r_step - STEP_W'(STEP_FEED + 1));
        end
    end

    always_comb begin
        dx  = 5'({1'b0, r_x}) - 5'({1'b0, r_bx});
        dy  = (MAP_DIMS == 1) ? 5'sd0 : 5'({1'b0, r_y}) - 5'({1'b0, r_by});
        ld2 = 9'(10'(dx * dx)) + 9'(10'(dy * dy));
    end

    always_comb begin
        exp_e = 17'd0;
        if (prod[PROD_W-1:20] == '0) begin
            exp_e = (prod[19:12] == 8'd0) ? 17'h10000 : {1'b0, EXP_TAB[prod[19:12]]};
        end
    end

    assign gain_sum = prod[32:0] + 33'd32768;
    assign rnd      = (prod + PROD_W'(32768)) >>> 16;
    assign new_w    = w_attr[k_r] + rnd[ATTR_W-1:0];
    assign dist_sum = r_acc + prod[DIST_W-1:0];

    always_comb begin
        upd_word = r_neww;
        if (r_state == S_UPD && r_step > STEP_W'(STEP_FEED)) begin
            upd_word[k_r*ATTR_W +: ATTR_W] = new_w;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_SRCH && r_step < STEP_W'(ATTRS)) begin
            mul_a = MUL_W'(diff[k_s]);
            mul_b = MUL_W'(diff[k_s]);
        end else if (r_state == S_UPD) begin
            if (r_step == 3'd0) begin
                mul_a = signed'({1'b0, r_scale});
                mul_b = signed'({16'd0, ld2});
            end else if (r_step == 3'd1) begin
                mul_a = signed'({9'd0, r_lr});
                mul_b = signed'({8'd0, exp_e});
            end else if (r_step >= STEP_W'(STEP_FEED)
                         && r_step < STEP_W'(STEP_FEED + ATTRS)) begin
                mul_a = signed'({9'd0, r_gain});
                mul_b = MUL_W'(diff[k_f]);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_unit  = r_unit;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_cmd == CMD_TRAIN || i_cmd == CMD_QUERY)) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (srch_end) begin
                    n_unit = last_unit ? '0 : r_unit + 1'b1;
                    if (last_unit) begin
                        n_state = (r_cmd == CMD_TRAIN) ? S_UPD : S_OUT;
                    end
                end
            end
            S_UPD: begin
                if (upd_end) begin
                    n_unit = last_unit ? '0 : r_unit + 1'b1;
                    if (last_unit) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_unit  = '0;
            end
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        waddr  = r_unit;
        wdata  = upd_word;
        if (r_state == S_UPD) begin
            mem_we = upd_end;
        end else if (in_acc && i_cmd == CMD_LOAD
                     && {1'b0, i_unit_index} < (UNIT_W+1)'(UNIT_COUNT)) begin
            mem_we = 1'b1;
            waddr  = i_unit_index;
            wdata  = {i_attr_c, i_attr_b, i_attr_a};
        end
    end

    som_wmem u_wmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (n_unit),
        .o_rdata (rdata)
    );

    som_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_unit   <= '0;
            r_step   <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_ovalid <= 1'b0;
            r_lr     <= LR_RESET;
        end else begin
            r_state <= n_state;
            r_unit  <= n_unit;
            if (i_cfg_valid) begin
                r_lr <= i_cfg_data;
            end
            if (srch_end || upd_end) begin
                r_step <= '0;
                if (last_unit) begin
                    r_x <= '0;
                    r_y <= '0;
                end else if (x_last) begin
                    r_x <= '0;
                    r_y <= r_y + 1'b1;
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end else if (r_state == S_SRCH || r_state == S_UPD) begin
                r_step <= r_step + 1'b1;
            end
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd     <= i_cmd;
            r_scale   <= i_neighborhood_scale;
            r_samp[0] <= i_attr_a;
            r_samp[1] <= i_attr_b;
            r_samp[2] <= i_attr_c;
        end
        if (r_state == S_SRCH) begin
            if (r_step == 3'd0) begin
                r_acc <= '0;
            end else if (!srch_end) begin
                r_acc <= dist_sum;
            end
            if (srch_end && (r_unit == '0 || dist_sum < r_best)) begin
                r_best <= dist_sum;
                r_bi   <= r_unit;
                r_bx   <= r_x;
                r_by   <= r_y;
            end
        end
        if (r_state == S_UPD) begin
            if (r_step == 3'd2) begin
                r_gain <= gain_sum[31:16];
                r_neww <= rdata;
            end else if (r_step > STEP_W'(STEP_FEED)) begin
                r_neww <= upd_word;
            end
        end
        if (r_state == S_OUT && out_free) begin
            r_obi   <= r_bi;
            r_obx   <= r_bx;
            r_oby   <= r_by;
            r_odist <= r_best;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_bmu_index     = r_obi;
    assign o_coord_x       = r_obx;
    assign o_coord_y       = r_oby;
    assign o_best_distance = r_odist;

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unit <= UNIT_W'(UNIT_COUNT - 1))
        else $error("unit counter beyond lattice");

    a_start_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_cmd == CMD_TRAIN || i_cmd == CMD_QUERY) |=> r_state == S_SRCH)
        else $error("search did not start");

    a_best_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch_end && r_unit != '0 |=> r_best <= $past(r_best))
        else $error("best distance grew during search");

    a_busy_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we && r_state != S_IDLE |-> upd_end)
        else $error("weight write outside update step");
endmodule

// ===== test/som_scoreboard.sv =====
`timescale 1ns / 1ps
module som_scoreboard (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [som_pkg::CMD_W-1:0]         i_cmd,
    input  logic [som_pkg::UNIT_W-1:0]        i_unit_index,
    input  logic signed [som_pkg::ATTR_W-1:0] i_attr_a,
    input  logic signed [som_pkg::ATTR_W-1:0] i_attr_b,
    input  logic signed [som_pkg::ATTR_W-1:0] i_attr_c,
    input  logic [som_pkg::SCALE_W-1:0]       i_neighborhood_scale,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [som_pkg::UNIT_W-1:0]        i_bmu_index,
    input  logic [som_pkg::COORD_W-1:0]       i_coord_x,
    input  logic [som_pkg::COORD_W-1:0]       i_coord_y,
    input  logic [som_pkg::DIST_W-1:0]        i_best_distance,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [som_pkg::LR_W-1:0]          i_cfg_data,
    output int                                o_errors,
    output int                                o_pending
);
    import som_pkg::*;

    typedef struct packed {
        logic [UNIT_W-1:0]  bmu;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIST_W-1:0]  sq_dist;
    } t_match;

    localparam int UNITS = 256;
    localparam int WIDTH = 16;

    t_match           match_q[$];
    logic signed [15:0] weights [UNITS][3];
    logic [15:0]      gain_peak;
    logic [15:0]      decay_tab [EXP_N];

    initial begin
        longint unsigned r;
        longint unsigned e;
        r = 64'd1 << 32;
        for (int i = 0; i < EXP_N; i++) begin
            e = (r + 64'd32768) >> 16;
            decay_tab[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
            r = (r * 64'd4034748382 + 64'h8000_0000) >> 32;
        end
        o_errors  = 0;
        gain_peak = LR_RESET;
    end

    assign o_pending = match_q.size();

    function automatic longint unsigned neighbour_gain(longint unsigned scale, int ld2);
        longint unsigned a;
        longint unsigned e;
        a = scale * longint'(ld2);
        if (a >= (64'd16 << 16)) return 0;
        e = ((a >> 12) == 0) ? 64'd65536 : longint'(decay_tab[a >> 12]);
        return (longint'(gain_peak) * e + 64'd32768) >> 16;
    endfunction

    task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [7:0] idx,
                                 input logic signed [15:0] s [3], input logic [23:0] scale);
        longint unsigned best;
        longint unsigned d;
        longint signed   df;
        longint signed   p;
        int              bi;
        int              bx;
        int              by;
        int              dx;
        int              dy;
        longint unsigned g;
        t_match          m;
        best = 0;
        bi   = 0;
        if (cmd == CMD_LOAD) begin
            for (int k = 0; k < 3; k++) weights[idx][k] = s[k];
            return;
        end
        if (cmd != CMD_TRAIN && cmd != CMD_QUERY) return;
        for (int u = 0; u < UNITS; u++) begin
            d = 0;
            for (int k = 0; k < 3; k++) begin
                df = longint'(weights[u][k]) - longint'(s[k]);
                d += df * df;
            end
            if (u == 0 || d < best) begin
                best = d;
                bi   = u;
            end
        end
        bx = bi % WIDTH;
        by = bi / WIDTH;
        if (cmd == CMD_TRAIN) begin
            for (int u = 0; u < UNITS; u++) begin
                dx = (u % WIDTH) - bx;
                dy = (u / WIDTH) - by;
                g  = neighbour_gain(longint'(scale), dx * dx + dy * dy);
                for (int k = 0; k < 3; k++) begin
                    p = longint'(g) * (longint'(s[k]) - longint'(weights[u][k]));
                    weights[u][k] = 16'(longint'(weights[u][k]) + ((p + 32768) >>> 16));
                end
            end
        end
        m.bmu     = bi[7:0];
        m.x       = bx[3:0];
        m.y       = by[3:0];
        m.sq_dist = best[DIST_W-1:0];
        match_q.push_back(m);
    endtask

    always @(posedge i_clk) begin
        logic signed [15:0] s [3];
        t_match m;
        if (!i_rst_n) begin
            gain_peak = LR_RESET;
            match_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) gain_peak = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (match_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("ERROR: unexpected result bmu=%0d", i_bmu_index);
                end else begin
                    m = match_q.pop_front();
                    if (i_bmu_index !== m.bmu || i_coord_x !== m.x || i_coord_y !== m.y
                            || i_best_distance !== m.sq_dist) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display(
                                "ERROR: exp bmu=%0d x=%0d y=%0d d=%0d, got bmu=%0d x=%0d y=%0d d=%0d",
                                m.bmu, m.x, m.y, m.sq_dist, i_bmu_index, i_coord_x,
                                i_coord_y, i_best_distance);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                s[0] = i_attr_a;
                s[1] = i_attr_b;
                s[2] = i_attr_c;
                apply_command(i_cmd, i_unit_index, s, i_neighborhood_scale);
            end
        end
    end
endmodule

// ===== test/self_organizing_map_engine_tb.sv =====
`timescale 1ns / 1ps
module self_organizing_map_engine_tb;
    import som_pkg::*;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [CMD_W-1:0]          i_cmd;
    logic [UNIT_W-1:0]         i_unit_index;
    logic signed [ATTR_W-1:0]  i_attr_a;
    logic signed [ATTR_W-1:0]  i_attr_b;
    logic signed [ATTR_W-1:0]  i_attr_c;
    logic [SCALE_W-1:0]        i_neighborhood_scale;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [UNIT_W-1:0]         o_bmu_index;
    logic [COORD_W-1:0]        o_coord_x;
    logic [COORD_W-1:0]        o_coord_y;
    logic [DIST_W-1:0]         o_best_distance;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [LR_W-1:0]           i_cfg_data;

    int   errors;
    int   pending;
    int   idle_pct;
    int   stall_pct;
    logic long_hold;
    logic hold_req;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    self_organizing_map_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_cmd(i_cmd), .i_unit_index(i_unit_index),
        .i_attr_a(i_attr_a), .i_attr_b(i_attr_b), .i_attr_c(i_attr_c),
        .i_neighborhood_scale(i_neighborhood_scale),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_bmu_index(o_bmu_index), .o_coord_x(o_coord_x), .o_coord_y(o_coord_y),
        .o_best_distance(o_best_distance),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    som_scoreboard u_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_cmd(i_cmd), .i_unit_index(i_unit_index),
        .i_attr_a(i_attr_a), .i_attr_b(i_attr_b), .i_attr_c(i_attr_c),
        .i_neighborhood_scale(i_neighborhood_scale),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_bmu_index(o_bmu_index), .i_coord_x(o_coord_x), .i_coord_y(o_coord_y),
        .i_best_distance(o_best_distance),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (long_hold) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // hold the result side off for a long stretch
    initial begin
        long_hold = 1'b0;
        wait (hold_req);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (6000) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [7:0] idx,
                             input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c, input logic [23:0] scale);
        i_in_valid           <= 1'b1;
        i_cmd                <= cmd;
        i_unit_index         <= idx;
        i_attr_a             <= a;
        i_attr_b             <= b;
        i_attr_c             <= c;
        i_neighborhood_scale <= scale;
        do @(posedge i_clk); while (!o_in_ready);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [15:0] rate);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rate;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        int          pick;
        logic [23:0] scale;
        pick  = $urandom_range(99);
        scale = ($urandom_range(1) == 1) ? 24'($urandom) : 24'($urandom_range(1 << 17));
        if (pick < 70)
            send_item(CMD_LOAD, 8'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 24'($urandom));
        else if (pick < 83)
            send_item(CMD_TRAIN, 8'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), scale);
        else if (pick < 96)
            send_item(CMD_QUERY, 8'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), scale);
        else
            send_item(CMD_NONE, 8'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), scale);
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_in_valid           = 1'b0;
        i_cmd                = CMD_LOAD;
        i_unit_index         = '0;
        i_attr_a             = '0;
        i_attr_b             = '0;
        i_attr_c             = '0;
        i_neighborhood_scale = '0;
        i_cfg_valid          = 1'b0;
        i_cfg_data           = '0;
        i_out_ready          = 1'b0;
        idle_pct             = 0;
        stall_pct            = 0;
        hold_req             = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every unit before any search
        for (int u = 0; u < 256; u++)
            send_item(CMD_LOAD, 8'(u), 16'($urandom), 16'($urandom), 16'($urandom), '0);
        send_item(CMD_LOAD, 8'd0, 16'h8000, 16'h8000, 16'h8000, '0);
        send_item(CMD_LOAD, 8'd255, 16'h7FFF, 16'h7FFF, 16'h7FFF, 24'hFFFFFF);
        send_item(CMD_LOAD, 8'd17, 16'h1234, 16'h0000, 16'hFFFF, '0);
        send_item(CMD_LOAD, 8'd200, 16'h1234, 16'h0000, 16'hFFFF, '0);
        send_item(CMD_QUERY, '0, 16'h1234, 16'h0000, 16'hFFFF, '0);
        send_item(CMD_QUERY, '0, 16'h7FFF, 16'h7FFF, 16'h7FFF, '0);
        send_item(CMD_QUERY, '0, 16'h8000, 16'h8000, 16'h8000, '0);
        send_item(CMD_LOAD, 8'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, '0);
        send_item(CMD_QUERY, '0, 16'h8000, 16'h8000, 16'h8000, '0);
        send_item(CMD_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        send_item(CMD_TRAIN, '0, 16'h0100, 16'hFF00, 16'h0010, '0);
        send_item(CMD_TRAIN, '0, 16'h7FFF, 16'h8000, 16'h0000, 24'hFFFFFF);
        send_item(CMD_TRAIN, '0, 16'h8000, 16'h7FFF, 16'h4000, 24'h004000);
        send_item(CMD_QUERY, '0, 16'h0100, 16'hFF00, 16'h0010, 24'hFFFFFF);
        write_rate(16'hFFFF);
        send_item(CMD_TRAIN, '0, 16'h2000, 16'hE000, 16'h0000, 24'h000001);
        send_item(CMD_QUERY, '0, 16'h2000, 16'hE000, 16'h0000, '0);
        write_rate(16'h0000);
        send_item(CMD_TRAIN, '0, 16'h8000, 16'h8000, 16'h8000, '0);
        send_item(CMD_QUERY, '0, 16'h8000, 16'h8000, 16'h8000, '0);

        write_rate(LR_RESET);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            for (int n = 0; n < 50; n++) random_item();
            write_rate((ph == 3) ? 16'd1 : 16'($urandom));
        end

        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        for (int n = 0; n < 6; n++)
            send_item(CMD_QUERY, '0, 16'($urandom), 16'($urandom), 16'($urandom), '0);
        for (int n = 0; n < 20; n++) random_item();

        drain();
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
